FILE: hdl/cfbd_pkg.sv
// ----------------------------------------------------------------------------
// Circular FIFO with burst drain - shared package
// Command codes, status codes, field widths and the request type passed
// from the front end to the back end.
// ----------------------------------------------------------------------------
package cfbd_pkg;

  // Default sizes of the block
  localparam int unsigned DEPTH_DEF      = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned MAX_BURST_DEF  = 64;

  // Fixed field widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned REQ_W  = 7;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 11;
  localparam int unsigned CAP_W  = 11;

  // Request queue between front and back end
  localparam int unsigned Q_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_DRAIN = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // Classified request: command and the clamped word count of a read
  typedef struct packed {
    cmd_e             cmd;
    logic [REQ_W-1:0] burst;
  } op_ctl_t;

endpackage

FILE: hdl/cfbd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered, enable-held read data.
// ----------------------------------------------------------------------------
module cfbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/cfbd_front.sv
// ----------------------------------------------------------------------------
// Circular FIFO with burst drain - front end
// Accepts input requests, decodes the command and clamps the read count.
// ----------------------------------------------------------------------------
module cfbd_front #(
  parameter int unsigned DATA_WIDTH = cfbd_pkg::DATA_WIDTH_DEF,
  parameter int unsigned MAX_BURST  = cfbd_pkg::MAX_BURST_DEF,
  localparam int unsigned TD_W = ((DATA_WIDTH + cfbd_pkg::REQ_W + 7) / 8) * 8
) (
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [TD_W-1:0]              s_axis_tdata,
  input  logic [cfbd_pkg::CMD_W-1:0]   s_axis_tuser,
  output logic                         op_valid_o,
  input  logic                         op_ready_i,
  output cfbd_pkg::op_ctl_t            op_ctl_o,
  output logic [DATA_WIDTH-1:0]        op_data_o
);

  logic [cfbd_pkg::REQ_W-1:0] req;
  logic [cfbd_pkg::REQ_W-1:0] burst;
  cfbd_pkg::cmd_e             cmd;

  assign cmd = cfbd_pkg::cmd_e'(s_axis_tuser);
  assign req = s_axis_tdata[DATA_WIDTH +: cfbd_pkg::REQ_W];

  // Clamp the read count: pop reads one word, drain 1..MAX_BURST
  always_comb begin
    burst = req;
    if (req == '0) begin
      burst = cfbd_pkg::REQ_W'(1);
    end else if (req > cfbd_pkg::REQ_W'(MAX_BURST)) begin
      burst = cfbd_pkg::REQ_W'(MAX_BURST);
    end
    if (cmd == cfbd_pkg::CMD_POP) begin
      burst = cfbd_pkg::REQ_W'(1);
    end
  end

  assign op_valid_o     = s_axis_tvalid;
  assign s_axis_tready  = op_ready_i;
  assign op_ctl_o.cmd   = cmd;
  assign op_ctl_o.burst = burst;
  assign op_data_o      = s_axis_tdata[DATA_WIDTH-1:0];

endmodule

FILE: hdl/cfbd_queue.sv
// ----------------------------------------------------------------------------
// Circular FIFO with burst drain - request queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cfbd_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  localparam int unsigned PW = (cfbd_pkg::Q_DEPTH > 1) ? $clog2(cfbd_pkg::Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(cfbd_pkg::Q_DEPTH + 1);

  logic [WIDTH-1:0] slot_q [cfbd_pkg::Q_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != CW'(cfbd_pkg::Q_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(cfbd_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(cfbd_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold payload in the slot
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

FILE: hdl/cfbd_back.sv
// ----------------------------------------------------------------------------
// Circular FIFO with burst drain - back end
// Owns the ring indices, occupancy, capacity register and word store, and
// executes requests into a one-entry output register.
// ----------------------------------------------------------------------------
module cfbd_back #(
  parameter int unsigned DEPTH      = cfbd_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = cfbd_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cfbd_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  logic                          op_valid_i,
  output logic                          op_ready_o,
  input  cfbd_pkg::op_ctl_t             op_ctl_i,
  input  logic [DATA_WIDTH-1:0]         op_data_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [DATA_WIDTH-1:0]         res_data_o,
  output cfbd_pkg::status_e             res_status_o,
  output logic [cfbd_pkg::OCC_W-1:0]    res_occ_o,
  output logic                          res_full_o,
  output logic                          res_empty_o,
  output logic                          res_last_o
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CW    = (CNT_W > cfbd_pkg::CAP_W) ? CNT_W : cfbd_pkg::CAP_W;
  localparam int unsigned RW    = cfbd_pkg::REQ_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e                      state_q, state_d;
  logic [cfbd_pkg::CAP_W-1:0]  cap_q;
  logic [AW-1:0]               head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]               count_q, count_d;
  logic [RW-1:0]               rem_q, rem_d;

  logic                        out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0]       out_data_q, out_data_d;
  cfbd_pkg::status_e           out_stat_q, out_stat_d;
  logic [cfbd_pkg::OCC_W-1:0]  out_occ_q, out_occ_d;
  logic                        out_full_q, out_full_d;
  logic                        out_empty_q, out_empty_d;
  logic                        out_last_q, out_last_d;

  logic [CW-1:0]               cap_ext, eff_cap;
  logic [CW-1:0]               head_inc, tail_inc;
  logic [AW-1:0]               head_nxt, tail_nxt;
  logic                        out_free, is_full_now;
  logic [RW-1:0]               n_words;

  logic                        ram_we, ram_re;
  logic [DATA_WIDTH-1:0]       ram_rdata;

  logic                        emit;
  logic [DATA_WIDTH-1:0]       emit_data;
  cfbd_pkg::status_e           emit_stat;
  logic [CW-1:0]               emit_occ;
  logic                        emit_last;

  // Effective capacity: zero acts as one, oversize acts as DEPTH
  always_comb begin
    cap_ext = CW'(cap_q);
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end
  end

  // Wrap indices at the effective capacity
  assign head_inc    = CW'(head_q) + CW'(1);
  assign tail_inc    = CW'(tail_q) + CW'(1);
  assign head_nxt    = (head_inc >= eff_cap) ? '0 : head_inc[AW-1:0];
  assign tail_nxt    = (tail_inc >= eff_cap) ? '0 : tail_inc[AW-1:0];
  assign is_full_now = (count_q >= eff_cap);
  assign n_words     = (CW'(op_ctl_i.burst) > count_q) ? count_q[RW-1:0] : op_ctl_i.burst;
  assign out_free    = !out_valid_q || res_ready_i;

  // Sequence requests
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    rem_d      = rem_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    op_ready_o = 1'b0;
    emit       = 1'b0;
    emit_data  = '0;
    emit_stat  = cfbd_pkg::STAT_OK;
    emit_occ   = count_q;
    emit_last  = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (op_valid_i && out_free) begin
          op_ready_o = 1'b1;
          case (op_ctl_i.cmd)
            cfbd_pkg::CMD_PUSH: begin
              emit = 1'b1;
              if (is_full_now) begin
                emit_stat = cfbd_pkg::STAT_FULL;
              end else begin
                ram_we   = 1'b1;
                tail_d   = tail_nxt;
                count_d  = count_q + CW'(1);
                emit_occ = count_q + CW'(1);
              end
            end
            cfbd_pkg::CMD_POP, cfbd_pkg::CMD_DRAIN: begin
              if (count_q == '0) begin
                emit      = 1'b1;
                emit_stat = cfbd_pkg::STAT_EMPTY;
              end else begin
                ram_re  = 1'b1;
                head_d  = head_nxt;
                count_d = count_q - CW'(1);
                rem_d   = n_words - RW'(1);
                state_d = ST_READ;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = ram_rdata;
          emit_last = (rem_q == '0);
          if (rem_q != '0) begin
            ram_re  = 1'b1;
            head_d  = head_nxt;
            count_d = count_q - CW'(1);
            rem_d   = rem_q - RW'(1);
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Load or drop the output register
  always_comb begin
    out_valid_d = out_valid_q && !res_ready_i;
    out_data_d  = out_data_q;
    out_stat_d  = out_stat_q;
    out_occ_d   = out_occ_q;
    out_full_d  = out_full_q;
    out_empty_d = out_empty_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_data_d  = emit_data;
      out_stat_d  = emit_stat;
      out_occ_d   = cfbd_pkg::OCC_W'(emit_occ);
      out_full_d  = (emit_occ >= eff_cap);
      out_empty_d = (emit_occ == '0);
      out_last_d  = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= cfbd_pkg::CAP_W'(DEPTH);
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    out_stat_q  <= out_stat_d;
    out_occ_q   <= out_occ_d;
    out_full_q  <= out_full_d;
    out_empty_q <= out_empty_d;
    out_last_q  <= out_last_d;
  end

  // Word store
  cfbd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (op_data_i),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign res_valid_o  = out_valid_q;
  assign res_data_o   = out_data_q;
  assign res_status_o = out_stat_q;
  assign res_occ_o    = out_occ_q;
  assign res_full_o   = out_full_q;
  assign res_empty_o  = out_empty_q;
  assign res_last_o   = out_last_q;

endmodule

FILE: hdl/circular_fifo_with_burst_drain_unit.sv
// ----------------------------------------------------------------------------
// Circular FIFO with burst drain - top level
// Ring buffer FIFO with push, pop, burst drain and status query commands.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis stream: tuser carries the command, tdata the
//   push word and the drain count. Results leave on the m_axis stream, one per
//   request, except a drain, which gives one result per word read and marks
//   the final one with tlast. capacity is written through cfg_we_i; the user
//   must write it only while idle, which the block does not enforce. A push
//   or query is answered from the idle state into the output register; a pop
//   or drain reads the word store through its registered read port and moves
//   each word to the output register as the next read goes out, taking no new
//   request until its last word is emitted. A two-entry request queue keeps
//   the input taking requests while the back end works. Reset clears indices
//   and occupancy and sets capacity to DEPTH; store contents are undefined
//   until written. When m_axis_tready is low the result is held and the back
//   end waits; the queue fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module circular_fifo_with_burst_drain_unit #(
  parameter int unsigned DEPTH      = cfbd_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = cfbd_pkg::DATA_WIDTH_DEF,
  parameter int unsigned MAX_BURST  = cfbd_pkg::MAX_BURST_DEF,
  localparam int unsigned IN_W  = ((DATA_WIDTH + cfbd_pkg::REQ_W + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((DATA_WIDTH + cfbd_pkg::OCC_W + 2 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cfbd_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [IN_W-1:0]               s_axis_tdata,   // data_in, max_count
  input  logic [cfbd_pkg::CMD_W-1:0]    s_axis_tuser,   // command
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OUT_W-1:0]              m_axis_tdata,   // data_out, occupancy, is_full, is_empty
  output logic [cfbd_pkg::STAT_W-1:0]   m_axis_tuser,   // status
  output logic                          m_axis_tlast
);

  localparam int unsigned QW = $bits(cfbd_pkg::op_ctl_t) + DATA_WIDTH;
  localparam int unsigned PAD_W = OUT_W - (DATA_WIDTH + cfbd_pkg::OCC_W + 2);

  logic                        fe_valid, fe_ready;
  cfbd_pkg::op_ctl_t           fe_ctl;
  logic [DATA_WIDTH-1:0]       fe_data;
  logic                        be_valid, be_ready;
  logic [QW-1:0]               be_word;
  cfbd_pkg::op_ctl_t           be_ctl;
  logic [DATA_WIDTH-1:0]       be_data;

  logic [DATA_WIDTH-1:0]       res_data;
  cfbd_pkg::status_e           res_status;
  logic [cfbd_pkg::OCC_W-1:0]  res_occ;
  logic                        res_full, res_empty;

  // Decode and clamp requests
  cfbd_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_BURST  (MAX_BURST)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .op_valid_o    (fe_valid),
    .op_ready_i    (fe_ready),
    .op_ctl_o      (fe_ctl),
    .op_data_o     (fe_data)
  );

  // Buffer classified requests
  cfbd_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fe_valid),
    .in_ready_o  (fe_ready),
    .in_data_i   ({fe_ctl, fe_data}),
    .out_valid_o (be_valid),
    .out_ready_i (be_ready),
    .out_data_o  (be_word)
  );

  assign be_ctl  = cfbd_pkg::op_ctl_t'(be_word[QW-1:DATA_WIDTH]);
  assign be_data = be_word[DATA_WIDTH-1:0];

  // Execute against the ring
  cfbd_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .op_valid_i   (be_valid),
    .op_ready_o   (be_ready),
    .op_ctl_i     (be_ctl),
    .op_data_i    (be_data),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_o   (res_data),
    .res_status_o (res_status),
    .res_occ_o    (res_occ),
    .res_full_o   (res_full),
    .res_empty_o  (res_empty),
    .res_last_o   (m_axis_tlast)
  );

  // Pack the result word
  assign m_axis_tdata = {PAD_W'(0), res_empty, res_full, res_occ, res_data};
  assign m_axis_tuser = res_status;

endmodule

FILE: verif/tb_circular_fifo_with_burst_drain_unit.sv
// ----------------------------------------------------------------------------
// Testbench - circular FIFO with burst drain
// A directed table covers the empty and full answers, both ends of the data
// and count fields, capacity 0 and 2047, and a shrink while words are held.
// Random requests then follow over several capacity settings. A scoreboard
// ring buffer predicts every result, which is checked against the m_axis
// stream in order, with random idling on both streams and a long sink stall.
// ----------------------------------------------------------------------------
module tb_circular_fifo_with_burst_drain_unit;
  import cfbd_pkg::*;

  localparam int unsigned IN_BITS      = ((DATA_WIDTH_DEF + REQ_W + 7) / 8) * 8;
  localparam int unsigned OUT_BITS     = ((DATA_WIDTH_DEF + OCC_W + 2 + 7) / 8) * 8;
  localparam int unsigned IDLE_PCT     = 11;
  localparam int unsigned HOLD_CYCLES  = 160;
  localparam int unsigned GUARD_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] word;
    logic [6:0]  count;
  } fifo_req_t;

  typedef struct packed {
    logic [31:0]      data;
    status_e          status;
    logic [OCC_W-1:0] occ;
    logic             full;
    logic             empty;
    logic             last;
  } fifo_rsp_t;

  typedef enum logic {STEP_SEND, STEP_CAP} step_kind_e;

  // One directed step: a request (arg is the count) or a capacity write (arg
  // is the value); typed rows carry a hand-written single result.
  typedef struct packed {
    step_kind_e       kind;
    cmd_e             cmd;
    logic [31:0]      word;
    logic [10:0]      arg;
    logic             typed;
    status_e          want_status;
    logic [31:0]      want_data;
    logic [OCC_W-1:0] want_occ;
    logic             want_full;
    logic             want_empty;
  } step_t;

  localparam int unsigned PLAN_LEN = 29;
  localparam step_t PLAN [PLAN_LEN] = '{
    '{STEP_SEND, CMD_QUERY, 32'h0,        11'd0,    1'b1, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b1},
    '{STEP_SEND, CMD_POP,   32'h0,        11'd0,    1'b1, STAT_EMPTY, 32'h0, 11'd0, 1'b0, 1'b1},
    '{STEP_SEND, CMD_DRAIN, 32'h0,        11'd5,    1'b1, STAT_EMPTY, 32'h0, 11'd0, 1'b0, 1'b1},
    '{STEP_SEND, CMD_PUSH,  32'hFFFFFFFF, 11'd0,    1'b1, STAT_OK,    32'h0, 11'd1, 1'b0, 1'b0},
    '{STEP_SEND, CMD_PUSH,  32'h00000000, 11'd127,  1'b1, STAT_OK,    32'h0, 11'd2, 1'b0, 1'b0},
    '{STEP_SEND, CMD_PUSH,  32'hA5A55A5A, 11'd64,   1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_SEND, CMD_POP,   32'h0,        11'd0,    1'b1, STAT_OK, 32'hFFFFFFFF, 11'd2, 1'b0, 1'b0},
    '{STEP_SEND, CMD_DRAIN, 32'h0,        11'd0,    1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_SEND, CMD_DRAIN, 32'h0,        11'd127,  1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_CAP,  CMD_QUERY, 32'h0,        11'd4,    1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_SEND, CMD_PUSH,  32'h00000001, 11'd0,    1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_SEND, CMD_PUSH,  32'h80000000, 11'd0,    1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_SEND, CMD_PUSH,  32'h12345678, 11'd0,    1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_SEND, CMD_PUSH,  32'hFEDCBA98, 11'd0,    1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_SEND, CMD_PUSH,  32'h5555AAAA, 11'd0,    1'b1, STAT_FULL,  32'h0, 11'd4, 1'b1, 1'b0},
    '{STEP_CAP,  CMD_QUERY, 32'h0,        11'd2,    1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_SEND, CMD_QUERY, 32'h0,        11'd0,    1'b1, STAT_OK,    32'h0, 11'd4, 1'b1, 1'b0},
    '{STEP_SEND, CMD_DRAIN, 32'h0,        11'd64,   1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_CAP,  CMD_QUERY, 32'h0,        11'd0,    1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_SEND, CMD_PUSH,  32'h0F0F0F0F, 11'd0,    1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_SEND, CMD_PUSH,  32'h33333333, 11'd0,    1'b1, STAT_FULL,  32'h0, 11'd1, 1'b1, 1'b0},
    '{STEP_SEND, CMD_POP,   32'h0,        11'd0,    1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_CAP,  CMD_QUERY, 32'h0,        11'd8,    1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_SEND, CMD_PUSH,  32'hC0FFEE01, 11'd0,    1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_SEND, CMD_PUSH,  32'h0BADF00D, 11'd0,    1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_SEND, CMD_PUSH,  32'h7FFFFFFF, 11'd0,    1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_CAP,  CMD_QUERY, 32'h0,        11'd2047, 1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_SEND, CMD_DRAIN, 32'h0,        11'd2,    1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0},
    '{STEP_SEND, CMD_POP,   32'h0,        11'd0,    1'b0, STAT_OK,    32'h0, 11'd0, 1'b0, 1'b0}
  };

  localparam int unsigned PHASES = 6;
  localparam logic [10:0] PHASE_CAP [PHASES] = '{11'd16, 11'd3, 11'd1024, 11'd1, 11'd7,
                                                 11'd2047};
  localparam int unsigned PHASE_ITEMS [PHASES] = '{35, 35, 35, 30, 35, 30};
  localparam int unsigned QUIET_PHASE = 4;
  localparam int unsigned HOLD_PHASE  = 0;
  localparam int unsigned PAUSE_PHASE = 2;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CAP_W-1:0]    cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata;   // data_in, max_count
  logic [CMD_W-1:0]    s_axis_tuser;   // command
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_BITS-1:0] m_axis_tdata;   // data_out, occupancy, is_full, is_empty
  logic [STAT_W-1:0]   m_axis_tuser;   // status
  logic                m_axis_tlast;

  // Scoreboard copy of the ring buffer
  logic [31:0]  ring_mem [DEPTH_DEF];
  int unsigned  head_idx = 0;
  int unsigned  tail_idx = 0;
  int unsigned  fill_cnt = 0;
  logic [10:0]  cap_reg  = 11'(DEPTH_DEF);
  fifo_rsp_t    expected_q [$];

  bit           quiet_mode = 1'b0;
  bit           hold_req   = 1'b0;
  int unsigned  cycle_count  = 0;
  int unsigned  mismatch_cnt = 0;
  int unsigned  req_cnt      = 0;
  int unsigned  rsp_cnt      = 0;
  int unsigned  cap_writes   = 0;
  int unsigned  full_cnt     = 0;
  int unsigned  empty_cnt    = 0;
  int unsigned  burst_cnt    = 0;

  circular_fifo_with_burst_drain_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Capacity in effect: zero acts as one, values past the depth clamp
  function automatic int unsigned cap_limit();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH_DEF) return DEPTH_DEF;
    return cap_reg;
  endfunction

  function automatic int unsigned next_slot(int unsigned idx);
    return (idx + 1 >= cap_limit()) ? 0 : idx + 1;
  endfunction

  function automatic fifo_rsp_t make_rsp(logic [31:0] word, status_e st, bit fin);
    fifo_rsp_t r;
    r.data   = word;
    r.status = st;
    r.occ    = OCC_W'(fill_cnt);
    r.full   = (fill_cnt >= cap_limit());
    r.empty  = (fill_cnt == 0);
    r.last   = fin;
    return r;
  endfunction

  // Advance the scoreboard by one accepted request and queue its results
  function automatic void predict_fifo(fifo_req_t rq);
    int unsigned n;
    logic [31:0] word;
    case (rq.cmd)
      CMD_PUSH: begin
        if (fill_cnt >= cap_limit()) begin
          full_cnt++;
          expected_q.push_back(make_rsp('0, STAT_FULL, 1'b1));
        end else begin
          ring_mem[tail_idx] = rq.word;
          tail_idx = next_slot(tail_idx);
          fill_cnt++;
          expected_q.push_back(make_rsp('0, STAT_OK, 1'b1));
        end
      end
      CMD_POP, CMD_DRAIN: begin
        if (fill_cnt == 0) begin
          empty_cnt++;
          expected_q.push_back(make_rsp('0, STAT_EMPTY, 1'b1));
        end else begin
          n = (rq.cmd == CMD_POP) ? 1 : rq.count;
          if (n == 0) n = 1;
          if (n > MAX_BURST_DEF) n = MAX_BURST_DEF;
          if (n > fill_cnt) n = fill_cnt;
          if (n > 1) burst_cnt++;
          for (int unsigned i = 0; i < n; i++) begin
            word = ring_mem[head_idx];
            head_idx = next_slot(head_idx);
            fill_cnt--;
            expected_q.push_back(make_rsp(word, STAT_OK, i + 1 == n));
          end
        end
      end
      default: begin
        expected_q.push_back(make_rsp('0, STAT_OK, 1'b1));
      end
    endcase
  endfunction

  // Offer one request after a random gap; hold it until accepted
  task automatic send_request(fifo_req_t rq, bit typed, fifo_rsp_t want);
    while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_BITS'({rq.count, rq.word});
    s_axis_tuser  = rq.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_fifo(rq);
    if (typed) begin
      void'(expected_q.pop_back());
      expected_q.push_back(want);
    end
    req_cnt++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_results();
    s_axis_tvalid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (GUARD_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [10:0] value);
    wait_results();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    cap_reg     = value;
    cap_writes++;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // Sink readiness: random idling, quiet stretch, and one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready = quiet_mode || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Check each result against the oldest prediction
  fifo_rsp_t got;
  fifo_rsp_t exp_rsp;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.data   = m_axis_tdata[31:0];
      got.occ    = m_axis_tdata[32 +: OCC_W];
      got.full   = m_axis_tdata[32 + OCC_W];
      got.empty  = m_axis_tdata[33 + OCC_W];
      got.status = status_e'(m_axis_tuser);
      got.last   = m_axis_tlast;
      rsp_cnt++;
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("[%0d] unexpected result: data %h status %0d occ %0d", cycle_count,
                   got.data, got.status, got.occ);
      end else begin
        exp_rsp = expected_q.pop_front();
        if (got !== exp_rsp) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("[%0d] mismatch  exp: data %h st %0d occ %0d full %b empty %b last %b",
                     cycle_count, exp_rsp.data, exp_rsp.status, exp_rsp.occ,
                     exp_rsp.full, exp_rsp.empty, exp_rsp.last);
            $display("[%0d]           got: data %h st %0d occ %0d full %b empty %b last %b",
                     cycle_count, got.data, got.status, got.occ,
                     got.full, got.empty, got.last);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus
  initial begin
    fifo_req_t   rq;
    fifo_rsp_t   want;
    int unsigned roll;
    int unsigned push_pct;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_QUERY;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == STEP_CAP) begin
        write_capacity(PLAN[i].arg);
      end else begin
        rq.cmd       = PLAN[i].cmd;
        rq.word      = PLAN[i].word;
        rq.count     = PLAN[i].arg[6:0];
        want.data    = PLAN[i].want_data;
        want.status  = PLAN[i].want_status;
        want.occ     = PLAN[i].want_occ;
        want.full    = PLAN[i].want_full;
        want.empty   = PLAN[i].want_empty;
        want.last    = 1'b1;
        send_request(rq, PLAN[i].typed, want);
      end
    end

    // Random phases; empty the buffer before each capacity change
    want = '0;
    for (int p = 0; p < PHASES; p++) begin
      rq.cmd   = CMD_DRAIN;
      rq.word  = '0;
      rq.count = 7'(MAX_BURST_DEF);
      while (fill_cnt != 0) send_request(rq, 1'b0, want);
      write_capacity(PHASE_CAP[p]);
      quiet_mode = (p == QUIET_PHASE);
      for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
        if (p == HOLD_PHASE && k == 6) hold_req = 1'b1;
        if (p == PAUSE_PHASE && k == 20) wait_results();
        push_pct = (fill_cnt < 4 || fill_cnt < cap_limit() / 2) ? 60 : 35;
        roll = $urandom_range(99);
        if (roll < push_pct) rq.cmd = CMD_PUSH;
        else if (roll < push_pct + (100 - push_pct) * 3 / 10) rq.cmd = CMD_POP;
        else if (roll < push_pct + (100 - push_pct) * 7 / 10) rq.cmd = CMD_DRAIN;
        else rq.cmd = CMD_QUERY;
        roll = $urandom_range(99);
        if (roll < 10) rq.word = '0;
        else if (roll < 20) rq.word = '1;
        else rq.word = $urandom;
        roll = $urandom_range(99);
        if (roll < 80) rq.count = 7'($urandom_range(8, 1));
        else if (roll < 95) rq.count = 7'($urandom_range(64, 9));
        else rq.count = 7'($urandom_range(127, 0));
        send_request(rq, 1'b0, want);
      end
    end
    quiet_mode = 1'b0;

    // Let the tail of the run drain
    wait_results();
    $display("Ran %0d requests through %0d capacity settings; %0d results checked.",
             req_cnt, cap_writes, rsp_cnt);
    $display("Saw %0d full rejects, %0d empty answers, %0d multi-word drains; %0d mismatches.",
             full_cnt, empty_cnt, burst_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
